// File: src/itp_pkg.sv
// Package for the integer token parser: widths, character codes, bases and
// the classified-character record passed from the front part to the back part.
// No dependencies.
package itp_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int MAX_TOKEN_LEN = 255;
  localparam int POS_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CHAR_W        = 8;
  localparam int RADIX_W       = 5;
  localparam int OUT_VALUE_W   = 32;
  localparam int OFFSET_W      = 8;
  localparam int DIGIT_W       = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CHAR_W-1:0]             char_t;
  typedef logic [RADIX_W-1:0]            radix_t;
  typedef logic [VALUE_BITS-1:0]         acc_t;
  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [OFFSET_W-1:0]           offset_t;
  typedef logic signed [OUT_VALUE_W-1:0] out_value_t;
  typedef logic [DIGIT_W-1:0]            digit_t;
  typedef logic [QPTR_W-1:0]             qptr_t;
  typedef logic [QCNT_W-1:0]             qcnt_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF    = 8'h66;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_LX    = 8'h78;
  localparam char_t CH_UX    = 8'h58;

  localparam radix_t RADIX_AUTO = 5'd0;
  localparam radix_t BASE_DEC   = 5'd10;
  localparam radix_t BASE_HEX   = 5'd16;

  // One character after classification.
  typedef struct packed {
    logic   is_nul;
    logic   is_space;
    logic   is_minus;
    logic   is_zero;
    logic   is_x;
    logic   is_digit;
    digit_t digit;
  } class_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic   valid;
    class_t item;
  } q_head_t;

endpackage

// File: src/itp_if.sv
// Channel interfaces of the integer token parser: characters in, results out
// and the radix register write. Depends on itp_pkg.
interface itp_char_if;
  logic            valid;
  logic            ready;
  itp_pkg::char_t  character;
  modport source(output valid, output character, input ready);
  modport sink(input valid, input character, output ready);
endinterface

interface itp_result_if;
  logic                 valid;
  logic                 ready;
  itp_pkg::out_value_t  value;
  itp_pkg::offset_t     end_offset;
  logic                 not_a_number;
  modport source(output valid, output value, output end_offset, output not_a_number,
                 input ready);
  modport sink(input valid, input value, input end_offset, input not_a_number,
               output ready);
endinterface

interface itp_cfg_if;
  logic             valid;
  logic             ready;
  itp_pkg::radix_t  radix;
  modport source(output valid, output radix, input ready);
  modport sink(input valid, input radix, output ready);
endinterface

// File: src/integer_token_parser.sv
// Integer token parser: one character transfer per cycle while the queue is not full; a NUL gives one result.
// With the queue empty, a NUL's result goes through a queue entry, then the output register,
// and transfers once the receiver is ready.
// The back part has a single multiply-add and takes one character per cycle while no NUL waits on
// the output register; a four-entry queue lets the front keep taking characters while a result waits.
// Reset (synchronous, active high) sets radix to 0, clears token state, queue and result.
// Depends on itp_pkg, the interfaces, itp_front, itp_queue and itp_back.
module integer_token_parser (
  input  logic         clk,
  input  logic         rst,
  itp_char_if.sink     chars,
  itp_cfg_if.sink      cfg,
  itp_result_if.source results
);

  logic             push;
  logic             pop;
  logic             full;
  itp_pkg::class_t  item;
  itp_pkg::q_head_t head;

  itp_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .item  (item)
  );

  itp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  itp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .cfg     (cfg),
    .results (results)
  );

endmodule

// File: src/itp_front.sv
// Front part: takes character transfers and classifies each character.
// Depends on itp_pkg and itp_char_if.
module itp_front (
  itp_char_if.sink        chars,
  input  logic            full,
  output logic            push,
  output itp_pkg::class_t item
);

  itp_pkg::char_t c;
  itp_pkg::char_t dsub;

  assign c           = chars.character;
  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    item          = '0;
    dsub          = '0;
    item.is_nul   = (c == itp_pkg::CH_NUL);
    item.is_space = (c == itp_pkg::CH_SPACE);
    item.is_minus = (c == itp_pkg::CH_MINUS);
    item.is_zero  = (c == itp_pkg::CH_ZERO);
    item.is_x     = (c == itp_pkg::CH_LX) || (c == itp_pkg::CH_UX);
    if (c >= itp_pkg::CH_ZERO && c <= itp_pkg::CH_NINE) begin
      item.is_digit = 1'b1;
      dsub          = c - itp_pkg::CH_ZERO;
    end else if (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LF) begin
      item.is_digit = 1'b1;
      dsub          = c - itp_pkg::CH_LA + 8'd10;
    end else if (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UF) begin
      item.is_digit = 1'b1;
      dsub          = c - itp_pkg::CH_UA + 8'd10;
    end
    item.digit = dsub[itp_pkg::DIGIT_W-1:0];
  end

endmodule

// File: src/itp_queue.sv
// Short queue of classified characters between the front and back parts.
// Depends on itp_pkg.
module itp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  itp_pkg::class_t  item,
  input  logic             pop,
  output logic             full,
  output itp_pkg::q_head_t head
);

  itp_pkg::class_t entries [itp_pkg::QUEUE_DEPTH];
  itp_pkg::qptr_t  wr_ptr;
  itp_pkg::qptr_t  rd_ptr;
  itp_pkg::qcnt_t  count;

  assign full       = (count == itp_pkg::qcnt_t'(itp_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/itp_back.sv
// Back part: token state machine, multiply-add accumulator, radix register
// and the result output register. Depends on itp_pkg and the interfaces.
module itp_back (
  input  logic             clk,
  input  logic             rst,
  input  itp_pkg::q_head_t head,
  output logic             pop,
  itp_cfg_if.sink          cfg,
  itp_result_if.source     results
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  phase_t          phase, phase_next;
  itp_pkg::acc_t   accumulator, accumulator_next;
  logic            negative, negative_next;
  itp_pkg::radix_t active_base, active_base_next;
  itp_pkg::pos_t   position, position_next;
  itp_pkg::pos_t   stop_offset, stop_offset_next;
  logic            junk_seen, junk_seen_next;
  itp_pkg::radix_t radix;
  itp_pkg::pos_t   pos_inc;
  itp_pkg::acc_t   signed_acc;
  itp_pkg::class_t it;

  assign it        = head.item;
  assign cfg.ready = 1'b1;

  // A NUL needs the output register; any other character never waits on it.
  assign pop = head.valid && (!it.is_nul || !results.valid || results.ready);

  assign pos_inc = (position < itp_pkg::pos_t'(itp_pkg::MAX_TOKEN_LEN)) ?
                   position + 1'b1 : position;
  assign signed_acc = negative ? (~accumulator + 1'b1) : accumulator;

  always_comb begin
    phase_t          ph;
    logic            handled;
    itp_pkg::radix_t base;
    ph                = phase;
    handled           = 1'b0;
    base              = active_base;
    phase_next        = phase;
    accumulator_next  = accumulator;
    negative_next     = negative;
    active_base_next  = active_base;
    position_next     = position;
    stop_offset_next  = stop_offset;
    junk_seen_next    = junk_seen;
    if (it.is_nul) begin
      phase_next       = PH_LEAD;
      accumulator_next = '0;
      negative_next    = 1'b0;
      active_base_next = '0;
      position_next    = '0;
      stop_offset_next = '0;
      junk_seen_next   = 1'b0;
    end else begin
      if (ph == PH_LEAD) begin
        if (it.is_space) begin
          position_next = pos_inc;
          handled       = 1'b1;
        end else if (it.is_minus) begin
          negative_next = 1'b1;
          phase_next    = PH_PREFIX;
          position_next = pos_inc;
          handled       = 1'b1;
        end else begin
          ph = PH_PREFIX;
        end
      end
      // The base is chosen at the first character after spaces and sign; in auto mode 0x or 0X selects hex.
      if (!handled && ph == PH_PREFIX) begin
        if (radix == itp_pkg::RADIX_AUTO) begin
          base = itp_pkg::BASE_DEC;
          if (it.is_zero) begin
            accumulator_next = '0;
            phase_next       = PH_ZERO;
            position_next    = pos_inc;
            handled          = 1'b1;
          end
        end else begin
          base = radix;
        end
        ph = PH_DIGITS;
      end
      if (!handled && ph == PH_ZERO) begin
        if (it.is_x) begin
          base          = itp_pkg::BASE_HEX;
          phase_next    = PH_DIGITS;
          position_next = pos_inc;
          handled       = 1'b1;
        end else begin
          ph = PH_DIGITS;
        end
      end
      if (!handled && ph == PH_DIGITS) begin
        phase_next = PH_DIGITS;
        if (it.is_digit && itp_pkg::radix_t'(it.digit) < base) begin
          accumulator_next = itp_pkg::acc_t'(accumulator * itp_pkg::acc_t'(base)
                                             + itp_pkg::acc_t'(it.digit));
          position_next    = pos_inc;
        end else begin
          junk_seen_next   = 1'b1;
          stop_offset_next = position;
          phase_next       = PH_STOPPED;
        end
      end
      active_base_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      accumulator   <= '0;
      negative      <= 1'b0;
      active_base   <= '0;
      position      <= '0;
      stop_offset   <= '0;
      junk_seen     <= 1'b0;
      radix         <= itp_pkg::RADIX_AUTO;
      results.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        radix <= cfg.radix;
      end
      if (pop) begin
        phase       <= phase_next;
        accumulator <= accumulator_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        position    <= position_next;
        stop_offset <= stop_offset_next;
        junk_seen   <= junk_seen_next;
      end
      if (pop && it.is_nul) begin
        results.valid        <= 1'b1;
        results.value        <= itp_pkg::out_value_t'(signed'(signed_acc));
        results.end_offset   <= itp_pkg::offset_t'(junk_seen ? stop_offset : position);
        results.not_a_number <= junk_seen;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stop_has_junk: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOPPED |-> junk_seen)
    else $error("stopped phase without a recorded stop character");

  a_stop_before_pos: assert property (@(posedge clk) disable iff (rst)
    junk_seen |-> stop_offset <= position)
    else $error("stop offset beyond current position");

  a_digits_base: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DIGITS |-> active_base != '0)
    else $error("digit phase with no base latched");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    pop && it.is_nul |=> phase == PH_LEAD && position == '0 && !junk_seen && results.valid)
    else $error("token end did not clear state and present a result");
`endif

endmodule

// File: tb/tb_integer_token_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_token_parser: random and directed number tokens,
// a predictor of the parse, and a scoreboard that checks every result transfer.
// Depends on itp_pkg, the channel interfaces and the integer_token_parser top level.
import itp_pkg::*;

typedef enum logic [2:0] {
  SCAN_LEAD,
  SCAN_SIGNED,
  SCAN_ZERO,
  SCAN_DIGITS,
  SCAN_STOPPED
} scan_t;

typedef struct {
  out_value_t value;
  offset_t    end_offset;
  logic       not_a_number;
} token_result_t;

class token_checker;
  localparam logic [5:0] NOT_A_DIGIT = 6'd32;

  radix_t        radix;
  scan_t         scan;
  acc_t          acc;
  logic          neg;
  radix_t        base;
  pos_t          pos;
  pos_t          stop_at;
  logic          junk;
  token_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   chars_taken;
  int unsigned   results_checked;
  int unsigned   stopped_early;

  function new();
    radix = RADIX_AUTO;
    clear_token();
  endfunction

  function void clear_token();
    scan    = SCAN_LEAD;
    acc     = '0;
    neg     = 1'b0;
    base    = '0;
    pos     = '0;
    stop_at = '0;
    junk    = 1'b0;
  endfunction

  function void set_radix(radix_t r);
    radix = r;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  function logic [5:0] digit_value(char_t c);
    if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return 6'(c - CH_LA + 10);
    if (c >= CH_UA && c <= CH_UF) return 6'(c - CH_UA + 10);
    return NOT_A_DIGIT;
  endfunction

  function void advance();
    if (pos < pos_t'(MAX_TOKEN_LEN)) pos++;
  endfunction

  // Runs one accepted character through the parse and queues a result on NUL.
  function void take_char(char_t c);
    logic [5:0]    d;
    token_result_t r;
    acc_t          v;
    chars_taken++;
    if (c == CH_NUL) begin
      v = neg ? acc_t'(-acc) : acc;
      r.value        = out_value_t'(v);
      r.end_offset   = junk ? offset_t'(stop_at) : offset_t'(pos);
      r.not_a_number = junk;
      pending_results.push_back(r);
      clear_token();
      return;
    end
    if (scan == SCAN_LEAD) begin
      if (c == CH_SPACE) begin
        advance();
        return;
      end
      if (c == CH_MINUS) begin
        neg  = 1'b1;
        scan = SCAN_SIGNED;
        advance();
        return;
      end
      scan = SCAN_SIGNED;
    end
    if (scan == SCAN_SIGNED) begin
      if (radix == RADIX_AUTO) begin
        base = BASE_DEC;
        if (c == CH_ZERO) begin
          acc  = '0;
          scan = SCAN_ZERO;
          advance();
          return;
        end
      end else begin
        base = radix;
      end
      scan = SCAN_DIGITS;
    end
    if (scan == SCAN_ZERO) begin
      if (c == CH_LX || c == CH_UX) begin
        base = BASE_HEX;
        scan = SCAN_DIGITS;
        advance();
        return;
      end
      scan = SCAN_DIGITS;
    end
    if (scan == SCAN_DIGITS) begin
      d = digit_value(c);
      if (d < 6'(base)) begin
        acc = acc * acc_t'(base) + acc_t'(d);
        advance();
      end else begin
        junk    = 1'b1;
        stop_at = pos;
        scan    = SCAN_STOPPED;
      end
    end
  endfunction

  task report(string msg);
    mismatches++;
    $display("ERROR [%0t] %s", $realtime, msg);
  endtask

  task check_result(out_value_t value, offset_t end_offset, logic not_a_number);
    token_result_t r;
    string         bad;
    if (pending_results.size() == 0) begin
      report($sformatf("result with nothing expected: value %0d offset %0d nan %0b",
                       value, end_offset, not_a_number));
      return;
    end
    r = pending_results.pop_front();
    results_checked++;
    if (r.not_a_number) stopped_early++;
    bad = "";
    if (value !== r.value)
      bad = {bad, $sformatf(" value %0d (want %0d)", value, r.value)};
    if (end_offset !== r.end_offset)
      bad = {bad, $sformatf(" end_offset %0d (want %0d)", end_offset, r.end_offset)};
    if (not_a_number !== r.not_a_number)
      bad = {bad, $sformatf(" not_a_number %0b (want %0b)", not_a_number, r.not_a_number)};
    if (bad != "") report($sformatf("result %0d:%s", results_checked, bad));
  endtask
endclass

module tb_integer_token_parser;
  localparam int          HALF_PERIOD   = 5;
  localparam int          CYCLE_LIMIT   = 400_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_CHARS   = 150;
  localparam int          PHASES        = 8;
  localparam char_t       CH_TOP        = 8'hFF;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        hold_rx = 1'b0;
  int unsigned long_tokens = 0;
  char_t       token_q[$];
  token_checker sb;

  radix_t radix_plan[PHASES] = '{RADIX_AUTO, BASE_DEC, 5'd31, 5'd1,
                                 BASE_HEX, 5'd17, 5'd2, RADIX_AUTO};
  int unsigned send_idle_plan[4]  = '{0, 75, 0, 19};
  int unsigned recv_stall_plan[4] = '{0, 0, 75, 19};

  itp_char_if   chars_if ();
  itp_cfg_if    cfg_if ();
  itp_result_if res_if ();

  integer_token_parser u_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .cfg     (cfg_if),
    .results (res_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Watches every channel; a character transfer is noted before a result is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_radix(cfg_if.radix);
      if (chars_if.valid && chars_if.ready) sb.take_char(chars_if.character);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.value, res_if.end_offset, res_if.not_a_number);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One long receiver hold-off so that results back up and the input stalls.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  function automatic char_t digit_char(int unsigned d);
    if (d < 10) return char_t'(CH_ZERO + d);
    return char_t'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
  endfunction

  // Mostly well-formed tokens with random content; the rest is noise.
  function automatic void build_token(radix_t r, bit long_one);
    int unsigned n;
    int unsigned span;
    token_q.delete();
    if (!long_one && $urandom_range(99) < 20) begin
      n = $urandom_range(8);
      repeat (n) token_q.push_back(char_t'($urandom_range(255, 1)));
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      repeat (n) token_q.push_back(CH_SPACE);
      if ($urandom_range(9) < 3) token_q.push_back(CH_MINUS);
      span = (r == RADIX_AUTO) ? 10 : ((r > BASE_HEX) ? 16 : r);
      if (r == RADIX_AUTO && $urandom_range(1)) begin
        token_q.push_back(CH_ZERO);
        token_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
        span = 16;
      end
      n = long_one ? $urandom_range(270, 250) : $urandom_range(12);
      repeat (n) token_q.push_back(digit_char($urandom_range(span - 1)));
      if ($urandom_range(99) < (long_one ? 50 : 15)) begin
        n = $urandom_range(4, 1);
        repeat (n) token_q.push_back(char_t'($urandom_range(255, 1)));
      end
    end
    token_q.push_back(CH_NUL);
  endfunction

  // Leaves valid high after the transfer; the next call or wait_idle decides its value.
  task automatic send_char(char_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid     <= 1'b0;
      chars_if.character <= char_t'($urandom);
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.character <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
  endtask

  task automatic send_token();
    foreach (token_q[i]) send_char(token_q[i]);
  endtask

  task automatic send_text(string s);
    token_q.delete();
    for (int i = 0; i < s.len(); i++) token_q.push_back(char_t'(s[i]));
    token_q.push_back(CH_NUL);
    send_token();
  endtask

  task automatic write_radix(radix_t r);
    cfg_if.valid <= 1'b1;
    cfg_if.radix <= r;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // The extra edge lets the monitor record the final NUL before the count is read.
  task automatic wait_idle();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_chars;
    sb = new();
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.character = CH_NUL;
    cfg_if.valid       = 1'b0;
    cfg_if.radix       = RADIX_AUTO;
    res_if.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tokens at the reset radix: empty, all spaces, bare and broken prefixes,
    // a sign with no digits, mixed-case hex and a stop on the top character code.
    send_text("");
    send_text("  ");
    send_text("0x");
    send_text("0xz");
    send_text("-q");
    send_text("-");
    send_text("0XfF");
    token_q = '{CH_NINE, CH_TOP, CH_NUL};
    send_token();
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_radix(radix_plan[p]);
      send_idle_pct  = send_idle_plan[p % 4];
      recv_stall_pct = recv_stall_plan[p % 4];
      if (p == 0) hold_go = 1'b1;
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        build_token(radix_plan[p], 1'b0);
        phase_chars += token_q.size();
        send_token();
      end
      // Long tokens of 250 to 270 digits, mostly past the position counter's limit of 255, to reach saturation.
      if (p == 0 || p == 5) begin
        build_token(radix_plan[p], 1'b1);
        long_tokens++;
        send_token();
      end
      wait_idle();
    end

    $display("summary: %0d characters, %0d tokens checked (%0d stopped early, %0d long)",
             sb.chars_taken, sb.results_checked, sb.stopped_early, long_tokens);
    $display("summary: %0d radix settings, idle mixes none/sender/receiver/both, %0d-cycle hold",
             PHASES, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
